[hw/rtl/jhs_pkg.sv]
// shared types and constants for the jacobi heat stencil
package jhs_pkg;

  // fixed field widths
  localparam int ROW_W      = 16;
  localparam int COL_W      = 10;
  localparam int CFG_LEN_W  = 11;
  localparam int CFG_TOT_W  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_TOTAL  = 1'b1;

  // reset values of the registers
  localparam logic [CFG_LEN_W-1:0] ROW_LENGTH_RST = 11'd1024;
  localparam logic [CFG_TOT_W-1:0] ROW_TOTAL_RST  = 16'd1024;

  // per-item classification handed from front to back
  typedef struct packed {
    logic             emit_a;    // result for the cell above (or row 0 cell)
    logic             emit_b;    // own border value on the last row
    logic             a_calc;    // result a is a four-point average
    logic             a_sel_x;   // result a passes the sample through
    logic             frame_end; // final cell of the grid
    logic [ROW_W-1:0] a_row;
    logic [ROW_W-1:0] b_row;
    logic [COL_W-1:0] col;
  } jhs_ctl_t;

  localparam int CTL_W = $bits(jhs_ctl_t);

endpackage

[hw/rtl/jhs_ram.sv]
// generic single write, single read ram with registered read (read-first)
module jhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/jhs_front.sv]
// front end: raster counters, line stores and item classification
module jhs_front #(
  parameter int MAX_COLUMNS  = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [jhs_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [jhs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0]         in_sample_i,
  output logic                            push_o,
  input  logic                            full_i,
  output jhs_pkg::jhs_ctl_t               ctl_o,
  output logic [SAMPLE_WIDTH-1:0]         south_o,
  output logic [SAMPLE_WIDTH-1:0]         north_o,
  output logic [SAMPLE_WIDTH-1:0]         west_o,
  output logic [SAMPLE_WIDTH-1:0]         east_o,
  output logic [SAMPLE_WIDTH-1:0]         center_o
);
  import jhs_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam logic [16:0] MAXC_M1 = 17'(MAX_COLUMNS - 1);

  logic [CFG_LEN_W-1:0] len_q;
  logic [CFG_TOT_W-1:0] tot_q;
  logic [CW-1:0]        col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [16:0]          len_ext;
  logic [16:0]          cols_m1_ext;
  logic [CW-1:0]        cols_m1;
  logic [ROW_W-1:0]     rows_m1;
  logic                 accept;
  logic                 last_col, first_col, r0, r_last, ge2;
  logic [CW-1:0]        east_addr;

  logic                    s1_valid_q;
  jhs_ctl_t                s1_ctl_q;
  logic [CW-1:0]           s1_col_q;
  logic [SAMPLE_WIDTH-1:0] s1_x_q;
  logic [SAMPLE_WIDTH-1:0] cur_q, west_q;
  logic [SAMPLE_WIDTH-1:0] north_rd, east_rd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= ROW_LENGTH_RST;
      tot_q <= ROW_TOTAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ROW_LENGTH: len_q <= cfg_data_i[CFG_LEN_W-1:0];
        CFG_ROW_TOTAL:  tot_q <= cfg_data_i[CFG_TOT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective grid size, clamped to the supported range
  always_comb begin
    len_ext = 17'(len_q);
    priority if (len_ext < 17'd3) begin
      cols_m1_ext = 17'd2;
    end else if (len_ext > MAXC_M1) begin
      cols_m1_ext = MAXC_M1;
    end else begin
      cols_m1_ext = len_ext - 17'd1;
    end
    cols_m1 = cols_m1_ext[CW-1:0];
    rows_m1 = (tot_q < 16'd3) ? 16'd2 : tot_q - 16'd1;
  end

  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q && !full_i;
  assign in_ready_o = !s1_valid_q || push_o;

  // position of the incoming beat
  assign last_col  = (col_q == cols_m1);
  assign first_col = (col_q == '0);
  assign r0        = (row_q == '0);
  assign r_last    = (row_q == rows_m1);
  assign ge2       = !r0 && (row_q != 16'd1);
  assign east_addr = last_col ? '0 : col_q + CW'(1);

  // raster counters, a register write restarts the grid
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = r_last ? '0 : row_q + 16'd1;
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores: north holds row r-2, centre holds row r-1
  jhs_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_COLUMNS)) u_north (
    .clk_i   (clk_i),
    .we_i    (push_o),
    .waddr_i (s1_col_q),
    .wdata_i (cur_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (north_rd)
  );

  jhs_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_COLUMNS)) u_center (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (in_sample_i),
    .re_i    (accept),
    .raddr_i (east_addr),
    .rdata_o (east_rd)
  );

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // stage payload and classification
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q             <= in_sample_i;
      s1_col_q           <= col_q;
      s1_ctl_q.emit_a    <= r0 || ge2;
      s1_ctl_q.emit_b    <= r_last;
      s1_ctl_q.a_calc    <= ge2 && !first_col && !last_col;
      s1_ctl_q.a_sel_x   <= r0;
      s1_ctl_q.frame_end <= r_last && last_col;
      s1_ctl_q.a_row     <= r0 ? '0 : row_q - 16'd1;
      s1_ctl_q.b_row     <= row_q;
      s1_ctl_q.col       <= COL_W'(col_q);
    end
  end

  // centre value of the current column and its west neighbour
  always_ff @(posedge clk_i) begin
    if (push_o) begin
      cur_q  <= east_rd;
      west_q <= cur_q;
    end
  end

  assign ctl_o    = s1_ctl_q;
  assign south_o  = s1_x_q;
  assign north_o  = north_rd;
  assign west_o   = west_q;
  assign east_o   = east_rd;
  assign center_o = cur_q;

endmodule

[hw/rtl/jhs_queue.sv]
// short register queue between front and back
module jhs_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

[hw/rtl/jhs_back.sv]
// back end: four-point average and result sequencing into the output register
module jhs_back #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  jhs_pkg::jhs_ctl_t           ctl_i,
  input  logic [SAMPLE_WIDTH-1:0]     south_i,
  input  logic [SAMPLE_WIDTH-1:0]     north_i,
  input  logic [SAMPLE_WIDTH-1:0]     west_i,
  input  logic [SAMPLE_WIDTH-1:0]     east_i,
  input  logic [SAMPLE_WIDTH-1:0]     center_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]     out_value_o,
  output logic [jhs_pkg::ROW_W-1:0]   out_row_o,
  output logic [jhs_pkg::COL_W-1:0]   out_col_o,
  output logic                        out_last_o
);
  import jhs_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  logic              phase_q, phase_d;
  logic              valid_q, valid_d;
  logic [SW-1:0]     value_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              last_q;
  logic              out_free, load, sel_b;
  logic signed [SW+1:0] sum;
  logic [SW-1:0]     quarter, a_value;

  // floor of the four-point sum over four, fits without saturation
  always_comb begin
    sum = $signed({{2{north_i[SW-1]}}, north_i}) + $signed({{2{south_i[SW-1]}}, south_i})
        + $signed({{2{west_i[SW-1]}}, west_i}) + $signed({{2{east_i[SW-1]}}, east_i});
    quarter = sum[SW+1:2];
    a_value = ctl_i.a_calc ? quarter : (ctl_i.a_sel_x ? south_i : center_i);
  end

  assign out_free = !valid_q || out_ready_i;

  // one result a cycle from the queue head, while the output register is free
  always_comb begin
    load    = 1'b0;
    sel_b   = 1'b0;
    q_pop_o = 1'b0;
    phase_d = phase_q;
    if (q_valid_i) begin
      priority if (phase_q) begin
        if (out_free) begin
          load    = 1'b1;
          sel_b   = 1'b1;
          q_pop_o = 1'b1;
          phase_d = 1'b0;
        end
      end else if (ctl_i.emit_a) begin
        if (out_free) begin
          load = 1'b1;
          if (ctl_i.emit_b) begin
            phase_d = 1'b1;
          end else begin
            q_pop_o = 1'b1;
          end
        end
      end else if (ctl_i.emit_b) begin
        if (out_free) begin
          load    = 1'b1;
          sel_b   = 1'b1;
          q_pop_o = 1'b1;
        end
      end else begin
        q_pop_o = 1'b1;
      end
    end
  end

  assign valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  // output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= sel_b ? south_i : a_value;
      row_q   <= sel_b ? ctl_i.b_row : ctl_i.a_row;
      col_q   <= ctl_i.col;
      last_q  <= sel_b && ctl_i.frame_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_value_o = value_q;
  assign out_row_o   = row_q;
  assign out_col_o   = col_q;
  assign out_last_o  = last_q;

endmodule

[hw/rtl/jacobi_heat_stencil.sv]
// One Jacobi heat-diffusion step over a raster-order grid of signed fixed-point
// samples. One sample beat is taken per cycle while the queue is not full; each
// beat of the last row yields two result beats (cell above, then its own border
// value), issued by the single output register at one result a cycle when free.
// Border cells are copied, interior cells become the floor of the sum of their
// four neighbours over four. Row 0 results pass the front stage register, the
// queue and the output register; interior results come one row late. Two
// line-store rams of MAX_COLUMNS entries hold the two previous rows; they need
// no clearing pass. A register write restarts the grid at row 0, column 0.
module jacobi_heat_stencil #(
  parameter int MAX_COLUMNS  = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [jhs_pkg::CFG_IDX_W-1:0]         cfg_addr_i,
  input  logic [jhs_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  s_tvalid_i,
  output logic                                  s_tready_o,
  // fields from bit 0: sample
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata_i,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  // fields from bit 0: cell_value, cell_row, cell_column
  output logic [((SAMPLE_WIDTH+jhs_pkg::ROW_W+jhs_pkg::COL_W+7)/8)*8-1:0] m_tdata_o,
  // frame_end
  output logic                                  m_tlast_o
);
  import jhs_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int OUT_W = ((SW + ROW_W + COL_W + 7) / 8) * 8;
  localparam int Q_W   = CTL_W + 5 * SW;

  logic          push, full, pop, q_valid;
  jhs_ctl_t      f_ctl, b_ctl;
  logic [SW-1:0] f_south, f_north, f_west, f_east, f_center;
  logic [SW-1:0] b_south, b_north, b_west, b_east, b_center;
  logic [Q_W-1:0] q_in, q_out;
  logic [SW-1:0]    o_value;
  logic [ROW_W-1:0] o_row;
  logic [COL_W-1:0] o_col;

  // front end
  jhs_front #(.MAX_COLUMNS(MAX_COLUMNS), .SAMPLE_WIDTH(SW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .in_sample_i (s_tdata_i[SW-1:0]),
    .push_o      (push),
    .full_i      (full),
    .ctl_o       (f_ctl),
    .south_o     (f_south),
    .north_o     (f_north),
    .west_o      (f_west),
    .east_o      (f_east),
    .center_o    (f_center)
  );

  // queue between front and back
  assign q_in = {f_ctl, f_south, f_north, f_west, f_east, f_center};

  jhs_queue #(.WIDTH(Q_W), .DEPTH(4)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign {b_ctl, b_south, b_north, b_west, b_east, b_center} = q_out;

  // back end
  jhs_back #(.SAMPLE_WIDTH(SW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (pop),
    .ctl_i       (b_ctl),
    .south_i     (b_south),
    .north_i     (b_north),
    .west_i      (b_west),
    .east_i      (b_east),
    .center_i    (b_center),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_value_o (o_value),
    .out_row_o   (o_row),
    .out_col_o   (o_col),
    .out_last_o  (m_tlast_o)
  );

  // output beat packing
  assign m_tdata_o = OUT_W'({o_col, o_row, o_value});

endmodule

[hw/rtl/jhs_checker.sv]
// port-level checker for the jacobi heat stencil, bound to the top level
module jhs_checker #(
  parameter int SAMPLE_WIDTH = 32
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  m_tvalid_o,
  input logic                                  m_tready_i,
  input logic [((SAMPLE_WIDTH+jhs_pkg::ROW_W+jhs_pkg::COL_W+7)/8)*8-1:0] m_tdata_o,
  input logic                                  m_tlast_o
);
  import jhs_pkg::*;

  logic [ROW_W-1:0] out_row;

  assign out_row = m_tdata_o[SAMPLE_WIDTH +: ROW_W];

  // no result beat offered while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_tvalid_o)
    else $error("result beat offered during reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tlast_o))
    else $error("stalled result beat changed");

  // the grid end lies on the last row, which is at least row two
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tlast_o |-> out_row >= 16'd2)
    else $error("frame end on a row that cannot be last");

  // row index of a result never reaches the all-ones code
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> out_row != 16'hFFFF)
    else $error("result row out of range");

endmodule

bind jacobi_heat_stencil jhs_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_jhs_checker (.*);
